FILE: rtl/p2r_pkg.sv
// p2r_pkg: shared types, widths and constants for the polar to rectangular unit
// no dependencies; used by p2r_prep, p2r_cell and polar_to_rect_degrees_unit
package p2r_pkg;

    // field widths
    localparam int unsigned FIELD_W = 16;
    // datapath: q8.8 value scaled by a further 2^14
    localparam int unsigned DATA_W = 32;
    // angle accumulator: degrees times 2^20
    localparam int unsigned ANG_W = 29;
    localparam int unsigned EXTRA_BITS = 14;
    localparam int unsigned MAX_STAGES = 24;
    localparam int unsigned CORDIC_STAGES_DEF = 16;

    // angle units are 1/64 degree
    localparam logic signed [16:0] TURN_UNITS = 17'sd23040;
    localparam logic signed [16:0] TWO_TURN_UNITS = 17'sd46080;
    localparam logic signed [16:0] QUARTER_UNITS = 17'sd5760;
    localparam logic signed [16:0] EIGHTH_UNITS = 17'sd2880;

    // infinite-stage cordic gain 0.6072529350 in q2.30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    // quarter-turn codes
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    typedef struct packed {
        logic signed [FIELD_W-1:0] magnitude;
        logic signed [FIELD_W-1:0] angle_deg;
    } t_polar_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] real_part;
        logic signed [FIELD_W-1:0] imag_part;
    } t_rect_out;

    // state carried from cell to cell
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        t_quad                    quad;
    } t_cell_data;

    // round(atan(2^-i) in degrees times 2^20)
    function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
        logic signed [ANG_W-1:0] val;
        unique case (idx)
            0:       val = 29'sd47185920;
            1:       val = 29'sd27855475;
            2:       val = 29'sd14718068;
            3:       val = 29'sd7471121;
            4:       val = 29'sd3750058;
            5:       val = 29'sd1876857;
            6:       val = 29'sd938658;
            7:       val = 29'sd469357;
            8:       val = 29'sd234682;
            9:       val = 29'sd117342;
            10:      val = 29'sd58671;
            11:      val = 29'sd29335;
            12:      val = 29'sd14668;
            13:      val = 29'sd7334;
            14:      val = 29'sd3667;
            15:      val = 29'sd1833;
            16:      val = 29'sd917;
            17:      val = 29'sd458;
            18:      val = 29'sd229;
            19:      val = 29'sd115;
            20:      val = 29'sd57;
            21:      val = 29'sd29;
            22:      val = 29'sd14;
            23:      val = 29'sd7;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/p2r_prep.sv
// p2r_prep: front stage; wraps the angle, splits off the quarter turn and
// applies the gain compensation. depends on p2r_pkg
module p2r_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  p2r_pkg::t_polar_in    i_data,
    output logic                  o_valid,
    output p2r_pkg::t_cell_data   o_data
);

    logic signed [16:0] ang;
    logic signed [16:0] wrapped;
    logic signed [16:0] resid;
    p2r_pkg::t_quad     quad;
    logic signed [47:0] prod;
    logic signed [47:0] prod_rnd;

    logic                 r_valid;
    p2r_pkg::t_cell_data  r_data;
    p2r_pkg::t_cell_data  n_data;

    assign ang = 17'(i_data.angle_deg);

    // reduce into [0, one turn)
    always_comb begin
        priority if (ang < -p2r_pkg::TURN_UNITS) begin
            wrapped = ang + p2r_pkg::TWO_TURN_UNITS;
        end else if (ang < 17'sd0) begin
            wrapped = ang + p2r_pkg::TURN_UNITS;
        end else if (ang >= p2r_pkg::TURN_UNITS) begin
            wrapped = ang - p2r_pkg::TURN_UNITS;
        end else begin
            wrapped = ang;
        end
    end

    // nearest quarter turn, residual within +-45 degrees
    always_comb begin
        priority if (wrapped < p2r_pkg::EIGHTH_UNITS) begin
            quad  = p2r_pkg::QUAD_0;
            resid = wrapped;
        end else if (wrapped < p2r_pkg::QUARTER_UNITS + p2r_pkg::EIGHTH_UNITS) begin
            quad  = p2r_pkg::QUAD_90;
            resid = wrapped - p2r_pkg::QUARTER_UNITS;
        end else if (wrapped < 17'sd2 * p2r_pkg::QUARTER_UNITS + p2r_pkg::EIGHTH_UNITS) begin
            quad  = p2r_pkg::QUAD_180;
            resid = wrapped - 17'sd2 * p2r_pkg::QUARTER_UNITS;
        end else if (wrapped < 17'sd3 * p2r_pkg::QUARTER_UNITS + p2r_pkg::EIGHTH_UNITS) begin
            quad  = p2r_pkg::QUAD_270;
            resid = wrapped - 17'sd3 * p2r_pkg::QUARTER_UNITS;
        end else begin
            quad  = p2r_pkg::QUAD_0;
            resid = wrapped - p2r_pkg::TURN_UNITS;
        end
    end

    // magnitude times gain, rounded into the extended q8.8 scale
    assign prod     = 48'(i_data.magnitude) * 48'(p2r_pkg::GAIN_Q30);
    assign prod_rnd = prod + 48'sd32768;

    always_comb begin
        n_data.x    = prod_rnd[16 +: p2r_pkg::DATA_W];
        n_data.y    = '0;
        n_data.z    = p2r_pkg::ANG_W'(resid) <<< p2r_pkg::EXTRA_BITS;
        n_data.quad = quad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/p2r_cell.sv
// p2r_cell: one cordic rotation step with its own pipeline register
// depends on p2r_pkg
module p2r_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  p2r_pkg::t_cell_data   i_data,
    output logic                  o_valid,
    output p2r_pkg::t_cell_data   o_data
);

    localparam logic signed [p2r_pkg::ANG_W-1:0] ATAN = p2r_pkg::atan_entry(STAGE);

    logic signed [p2r_pkg::DATA_W-1:0] xs;
    logic signed [p2r_pkg::DATA_W-1:0] ys;

    logic                 r_valid;
    p2r_pkg::t_cell_data  r_data;
    p2r_pkg::t_cell_data  n_data;

    // arithmetic shift gives floor
    assign xs = i_data.x >>> STAGE;
    assign ys = i_data.y >>> STAGE;

    always_comb begin
        n_data.quad = i_data.quad;
        if (i_data.z >= 0) begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - ATAN;
        end else begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/polar_to_rect_degrees_unit.sv
// polar_to_rect_degrees_unit: top level, cordic polar to rectangular converter
// depends on p2r_pkg, p2r_prep and p2r_cell
//
// usage
// - input channel i_in_valid / o_in_ready carries one beat per polar pair:
//   signed q8.8 magnitude and signed angle in 1/64 degree (any 16-bit value,
//   wrapped modulo 360 degrees)
// - output channel o_out_valid / i_out_ready carries one beat per pair:
//   real = mag*cos, imag = mag*sin, q8.8, rounded to nearest, saturated
// - throughput: one beat per clock while o_in_ready is high, set by the unrolled row of cordic cells
// - pipeline: one front stage for angle wrap and gain multiply, one cell per
//   iteration (CORDIC_STAGES, at most MAX_STAGES), one output register with
//   rounding and quarter-turn fixup
// - stall: when the receiver holds i_out_ready low the finished result waits
//   in the output register and the next one lands in a skid register; only
//   when the skid register is full does the whole row freeze and
//   o_in_ready drop
// - reset: synchronous, active low, empties every stage; no beats are lost
//   or repeated around stalls
// - no state is carried from one beat to the next
module polar_to_rect_degrees_unit #(
    parameter int unsigned CORDIC_STAGES = p2r_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  p2r_pkg::t_polar_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output p2r_pkg::t_rect_out   o_out_data
);

    localparam int unsigned N_CELLS = (CORDIC_STAGES > p2r_pkg::MAX_STAGES) ?
                                      p2r_pkg::MAX_STAGES : CORDIC_STAGES;

    // chain of cell outputs: entry 0 is the front stage
    logic                 chain_valid [N_CELLS+1];
    p2r_pkg::t_cell_data  chain_data  [N_CELLS+1];

    logic                 en;
    logic                 out_fire;
    logic signed [p2r_pkg::DATA_W-1:0] rx;
    logic signed [p2r_pkg::DATA_W-1:0] ry;
    p2r_pkg::t_rect_out   fin_data;
    p2r_pkg::t_cell_data  last;

    logic                 r_out_valid;
    p2r_pkg::t_rect_out   r_out_data;
    logic                 r_skid_valid;
    p2r_pkg::t_rect_out   r_skid_data;

    // round half up by 2^14, then clamp to 16 bits
    function automatic logic signed [p2r_pkg::FIELD_W-1:0] round_sat(
        input logic signed [p2r_pkg::DATA_W-1:0] v
    );
        logic signed [p2r_pkg::DATA_W:0] t;
        logic signed [p2r_pkg::DATA_W-p2r_pkg::EXTRA_BITS:0] r;
        logic signed [p2r_pkg::FIELD_W-1:0] res;
        t = (p2r_pkg::DATA_W + 1)'(v) + (p2r_pkg::DATA_W + 1)'(1 << (p2r_pkg::EXTRA_BITS - 1));
        r = t[p2r_pkg::DATA_W:p2r_pkg::EXTRA_BITS];
        if (r > (p2r_pkg::DATA_W - p2r_pkg::EXTRA_BITS + 1)'(32767)) begin
            res = 16'sh7fff;
        end else if (r < -(p2r_pkg::DATA_W - p2r_pkg::EXTRA_BITS + 1)'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = r[p2r_pkg::FIELD_W-1:0];
        end
        return res;
    endfunction

    // whole row advances unless the skid register holds a result
    assign en         = !r_skid_valid;
    assign o_in_ready = en;
    assign out_fire   = r_out_valid && i_out_ready;

    p2r_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (chain_valid[0]),
        .o_data  (chain_data[0])
    );

    // one cell per cordic iteration
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        p2r_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    assign last = chain_data[N_CELLS];

    // exact quarter-turn rotation of the cordic result
    always_comb begin
        unique case (last.quad)
            p2r_pkg::QUAD_90: begin
                rx = -last.y;
                ry = last.x;
            end
            p2r_pkg::QUAD_180: begin
                rx = -last.x;
                ry = -last.y;
            end
            p2r_pkg::QUAD_270: begin
                rx = last.y;
                ry = -last.x;
            end
            default: begin
                rx = last.x;
                ry = last.y;
            end
        endcase
    end

    assign fin_data.real_part = round_sat(rx);
    assign fin_data.imag_part = round_sat(ry);

    // output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // row frozen, drain the skid register first
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (chain_valid[N_CELLS]) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (chain_valid[N_CELLS]) begin
            if (!r_out_valid || out_fire) begin
                r_out_data <= fin_data;
            end else begin
                r_skid_data <= fin_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
